// File: design/edc_pkg.sv
// edc_pkg: shared constants, command codes, sequencer states and the
// waiting-list memory control struct for the elevator dispatch controller
// no dependencies
package edc_pkg;

   localparam int FLOORS         = 5;
   localparam int CABIN_SLOTS    = 8;
   localparam int WAIT_DEPTH     = 16;
   localparam int QUEUE_DEPTH    = 32;
   localparam int POSTPONE_REACH = 8;

   localparam int FLOOR_W   = 3;
   localparam int PAIR_W    = 2 * FLOOR_W;
   localparam int WPTR_W    = $clog2(WAIT_DEPTH);
   localparam int WCNT_W    = $clog2(WAIT_DEPTH + 1);
   localparam int WADDR_W   = $clog2(FLOORS * WAIT_DEPTH);
   localparam int CIDX_W    = $clog2(CABIN_SLOTS);
   localparam int CCNT_W    = 4;
   localparam int QIDX_W    = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int PPCNT_W   = $clog2(POSTPONE_REACH + 1);

   localparam logic [1:0] CMD_CALL = 2'd0;
   localparam logic [1:0] CMD_ZONE = 2'd1;
   localparam logic [1:0] CMD_STOP = 2'd2;

   localparam logic [CCNT_W-1:0] CAP_RESET = 4'd8;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_STOP_SCAN,
      S_EXIT,
      S_DROP_SEARCH,
      S_DROP_SHIFT,
      S_BOARD_RD,
      S_BOARD_WR,
      S_PP_CHK,
      S_PP_SWAP,
      S_PP_SWAP2,
      S_DIR_SCAN,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic                 wr_en;
      logic [WADDR_W-1:0]   wr_addr;
      logic [FLOOR_W-1:0]   wr_data;
      logic                 rd_en;
      logic [WADDR_W-1:0]   rd_addr;
   } wait_ctl_type;

endpackage

// File: design/edc_wait_mem.sv
// edc_wait_mem: destination store of all per-floor waiting lists,
// one write and one registered read per cycle
// depends on edc_pkg
module edc_wait_mem (
   input  logic                          clock,
   input  edc_pkg::wait_ctl_type         ctl,
   output logic [edc_pkg::FLOOR_W-1:0]   rd_data
);

   logic [edc_pkg::FLOOR_W-1:0] mem_ff [edc_pkg::FLOORS * edc_pkg::WAIT_DEPTH];
   logic [edc_pkg::FLOOR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[ctl.wr_addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[ctl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/elevator_dispatch_controller_unit.sv
// Elevator dispatch controller: one transaction at a time is run by a small
// sequencer over a single compare/step datapath, and req_ready is high only while
// idle. A call passes through decode and finish; a zone report adds a direction
// scan over the cabin riders when the request queue is not empty. A stop adds a
// cabin scan and, when the cabin stops, an exit walk. For each exiting rider
// the exit walk searches and compacts the request queue. Boarding reads and then
// writes each rider, and postponing swaps the queue head (up to 8 swaps). The
// direction scan comes last. The longest stop is set by the queue walks of the
// exit loop. A stalled result transaction holds the sequencer in its finish
// state. No clearing pass.
// depends on edc_pkg and edc_wait_mem
module elevator_dispatch_controller_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [3:0]  csr_cabin_capacity,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [2:0]  req_floor,
   input  logic [2:0]  req_dest_floor,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_stopped,
   output logic        rsp_going_up,
   output logic        rsp_going_down,
   output logic        rsp_move_enable,
   output logic [3:0]  rsp_cabin_count,
   output logic [3:0]  rsp_exited_count,
   output logic [3:0]  rsp_entered_count,
   output logic        rsp_rejected
);

   localparam int FW = edc_pkg::FLOOR_W;
   localparam int PW = edc_pkg::PAIR_W;
   localparam int CW = edc_pkg::CCNT_W;
   localparam int QW = edc_pkg::QCNT_W;

   edc_pkg::state_type state_ff, state_in;

   logic [1:0]    cmd_ff;
   logic [FW-1:0] fl_ff, ds_ff, cur_ff;
   logic [CW-1:0] cap_ff;
   logic [PW-1:0] cab_ff [edc_pkg::CABIN_SLOTS];
   logic [CW-1:0] cab_fill_ff;
   logic [PW-1:0] q_ff [edc_pkg::QUEUE_DEPTH];
   logic [QW-1:0] q_fill_ff;
   logic [edc_pkg::WCNT_W-1:0] wcnt_ff  [edc_pkg::FLOORS];
   logic [edc_pkg::WPTR_W-1:0] whead_ff [edc_pkg::FLOORS];
   logic [1:0]    dir_ff;
   logic [CW-1:0] idx_ff, wr_ff;
   logic [QW-1:0] j_ff;
   logic [edc_pkg::PPCNT_W-1:0] k_ff;
   logic [PW-1:0] tmp_ff, pair_ff;
   logic          found_ff, stopped_ff, rejected_ff;
   logic [CW-1:0] exited_ff, entered_ff;

   logic          rsp_valid_ff, rsp_stopped_ff, rsp_up_ff, rsp_down_ff, rsp_move_ff;
   logic          rsp_rejected_ff;
   logic [CW-1:0] rsp_cabin_ff, rsp_exited_ff, rsp_entered_ff;

   edc_pkg::wait_ctl_type wctl;
   logic [FW-1:0]         wrd_data;

   logic [CW-1:0] eff_cap;
   logic          fl_ok, ds_ok, call_ok, pp_start, head_here;
   logic [edc_pkg::WCNT_W-1:0] fl_cnt;
   logic [edc_pkg::WPTR_W-1:0] fl_tail;
   logic [PW-1:0] cab_rd, q_head, q_j, q_j1, q_k;
   logic [edc_pkg::QIDX_W-1:0] k_idx;
   logic [FW-1:0] target;
   logic          out_free;

   edc_wait_mem u_wait_mem (
      .clock   (clock),
      .ctl     (wctl),
      .rd_data (wrd_data)
   );

   assign eff_cap = (cap_ff > CW'(edc_pkg::CABIN_SLOTS)) ? CW'(edc_pkg::CABIN_SLOTS) : cap_ff;
   assign fl_ok   = fl_ff < FW'(edc_pkg::FLOORS);
   assign ds_ok   = ds_ff < FW'(edc_pkg::FLOORS);

   always_comb begin
      fl_cnt  = '0;
      fl_tail = '0;
      if (fl_ok) begin
         fl_cnt  = wcnt_ff[fl_ff];
         fl_tail = whead_ff[fl_ff] + fl_cnt[edc_pkg::WPTR_W-1:0];
      end
   end

   assign call_ok = fl_ok && ds_ok && (fl_cnt < edc_pkg::WCNT_W'(edc_pkg::WAIT_DEPTH))
                    && (q_fill_ff < QW'(edc_pkg::QUEUE_DEPTH));

   assign cab_rd  = cab_ff[idx_ff[edc_pkg::CIDX_W-1:0]];
   assign q_head  = q_ff[0];
   assign q_j     = q_ff[j_ff[edc_pkg::QIDX_W-1:0]];
   assign q_j1    = q_ff[j_ff[edc_pkg::QIDX_W-1:0] + 1'b1];
   assign k_idx   = edc_pkg::QIDX_W'(k_ff);
   assign q_k     = q_ff[k_idx];
   assign head_here = q_head[PW-1:FW] == cur_ff;
   assign pp_start  = (cab_fill_ff == eff_cap) && (q_fill_ff != '0) && head_here;
   assign target    = found_ff ? q_head[FW-1:0] : q_head[PW-1:FW];
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         edc_pkg::S_IDLE: begin
            if (req_valid) state_in = edc_pkg::S_DECODE;
         end
         edc_pkg::S_DECODE: begin
            if (cmd_ff == edc_pkg::CMD_CALL) begin
               state_in = edc_pkg::S_FINISH;
            end else if ((cmd_ff == edc_pkg::CMD_ZONE || cmd_ff == edc_pkg::CMD_STOP) && fl_ok) begin
               state_in = (cmd_ff == edc_pkg::CMD_STOP) ? edc_pkg::S_STOP_SCAN
                                                         : edc_pkg::S_DIR_SCAN;
            end else begin
               state_in = edc_pkg::S_FINISH;
            end
         end
         edc_pkg::S_STOP_SCAN: begin
            if (idx_ff >= cab_fill_ff) begin
               if (found_ff || (wcnt_ff[cur_ff] != '0 && cab_fill_ff < eff_cap))
                  state_in = edc_pkg::S_EXIT;
               else
                  state_in = edc_pkg::S_DIR_SCAN;
            end
         end
         edc_pkg::S_EXIT: begin
            if (idx_ff >= cab_fill_ff)
               state_in = edc_pkg::S_BOARD_RD;
            else if (cab_rd[FW-1:0] == cur_ff)
               state_in = edc_pkg::S_DROP_SEARCH;
         end
         edc_pkg::S_DROP_SEARCH: begin
            if (j_ff >= q_fill_ff)
               state_in = edc_pkg::S_EXIT;
            else if (q_j == pair_ff)
               state_in = edc_pkg::S_DROP_SHIFT;
         end
         edc_pkg::S_DROP_SHIFT: begin
            if ((j_ff + QW'(1)) >= q_fill_ff) state_in = edc_pkg::S_EXIT;
         end
         edc_pkg::S_BOARD_RD: begin
            if (wcnt_ff[cur_ff] != '0 && cab_fill_ff < eff_cap)
               state_in = edc_pkg::S_BOARD_WR;
            else if (pp_start)
               state_in = edc_pkg::S_PP_CHK;
            else
               state_in = edc_pkg::S_DIR_SCAN;
         end
         edc_pkg::S_BOARD_WR: state_in = edc_pkg::S_BOARD_RD;
         edc_pkg::S_PP_CHK: begin
            if (k_ff == edc_pkg::PPCNT_W'(edc_pkg::POSTPONE_REACH)
                || (QW'(k_ff) + QW'(1)) >= q_fill_ff)
               state_in = edc_pkg::S_DIR_SCAN;
            else
               state_in = edc_pkg::S_PP_SWAP;
         end
         edc_pkg::S_PP_SWAP: state_in = edc_pkg::S_PP_SWAP2;
         edc_pkg::S_PP_SWAP2: begin
            // after the swap, slot k holds the old head
            state_in = (tmp_ff != q_k) ? edc_pkg::S_DIR_SCAN : edc_pkg::S_PP_CHK;
         end
         edc_pkg::S_DIR_SCAN: begin
            if (q_fill_ff == '0 || idx_ff >= cab_fill_ff) state_in = edc_pkg::S_FINISH;
         end
         edc_pkg::S_FINISH: begin
            if (out_free) state_in = edc_pkg::S_IDLE;
         end
         default: state_in = edc_pkg::S_IDLE;
      endcase
   end

   // outputs and memory control
   always_comb begin
      req_ready     = state_ff == edc_pkg::S_IDLE;
      wctl.wr_en    = (state_ff == edc_pkg::S_DECODE) && (cmd_ff == edc_pkg::CMD_CALL) && call_ok;
      wctl.wr_addr  = edc_pkg::WADDR_W'({fl_ff, fl_tail});
      wctl.wr_data  = ds_ff;
      wctl.rd_en    = state_ff == edc_pkg::S_BOARD_RD;
      wctl.rd_addr  = edc_pkg::WADDR_W'({cur_ff, whead_ff[cur_ff]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= edc_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff      <= edc_pkg::CAP_RESET;
         cab_fill_ff <= '0;
         q_fill_ff   <= '0;
         cur_ff      <= '0;
         dir_ff      <= '0;
         for (int f = 0; f < edc_pkg::FLOORS; f++) begin
            wcnt_ff[f]  <= '0;
            whead_ff[f] <= '0;
         end
      end else begin
         if (csr_write_enable) cap_ff <= csr_cabin_capacity;
         case (state_ff)
            edc_pkg::S_IDLE: begin
               if (req_valid) begin
                  cmd_ff <= req_command;
                  fl_ff  <= req_floor;
                  ds_ff  <= req_dest_floor;
               end
            end
            edc_pkg::S_DECODE: begin
               stopped_ff  <= 1'b0;
               rejected_ff <= 1'b0;
               exited_ff   <= '0;
               entered_ff  <= '0;
               idx_ff      <= '0;
               found_ff    <= 1'b0;
               if (cmd_ff == edc_pkg::CMD_CALL) begin
                  if (call_ok) begin
                     wcnt_ff[fl_ff] <= fl_cnt + 1'b1;
                     q_ff[q_fill_ff[edc_pkg::QIDX_W-1:0]] <= {fl_ff, ds_ff};
                     q_fill_ff <= q_fill_ff + 1'b1;
                  end else begin
                     rejected_ff <= 1'b1;
                  end
               end else if ((cmd_ff == edc_pkg::CMD_ZONE || cmd_ff == edc_pkg::CMD_STOP) && fl_ok) begin
                  cur_ff <= fl_ff;
               end
            end
            edc_pkg::S_STOP_SCAN: begin
               if (idx_ff < cab_fill_ff) begin
                  if (cab_rd[FW-1:0] == cur_ff) found_ff <= 1'b1;
                  idx_ff <= idx_ff + 1'b1;
               end else begin
                  idx_ff   <= '0;
                  wr_ff    <= '0;
                  found_ff <= 1'b0;
                  if (found_ff || (wcnt_ff[cur_ff] != '0 && cab_fill_ff < eff_cap))
                     stopped_ff <= 1'b1;
               end
            end
            edc_pkg::S_EXIT: begin
               if (idx_ff < cab_fill_ff) begin
                  idx_ff <= idx_ff + 1'b1;
                  if (cab_rd[FW-1:0] == cur_ff) begin
                     pair_ff   <= cab_rd;
                     j_ff      <= '0;
                     exited_ff <= exited_ff + 1'b1;
                  end else begin
                     // compact the riders who stay
                     cab_ff[wr_ff[edc_pkg::CIDX_W-1:0]] <= cab_rd;
                     wr_ff <= wr_ff + 1'b1;
                  end
               end else begin
                  cab_fill_ff <= wr_ff;
               end
            end
            edc_pkg::S_DROP_SEARCH: begin
               if (j_ff < q_fill_ff && q_j != pair_ff) j_ff <= j_ff + 1'b1;
            end
            edc_pkg::S_DROP_SHIFT: begin
               if ((j_ff + QW'(1)) < q_fill_ff) begin
                  q_ff[j_ff[edc_pkg::QIDX_W-1:0]] <= q_j1;
                  j_ff <= j_ff + 1'b1;
               end else begin
                  q_fill_ff <= q_fill_ff - 1'b1;
               end
            end
            edc_pkg::S_BOARD_RD: begin
               k_ff     <= '0;
               idx_ff   <= '0;
               found_ff <= 1'b0;
            end
            edc_pkg::S_BOARD_WR: begin
               cab_ff[cab_fill_ff[edc_pkg::CIDX_W-1:0]] <= {cur_ff, wrd_data};
               cab_fill_ff      <= cab_fill_ff + 1'b1;
               whead_ff[cur_ff] <= whead_ff[cur_ff] + 1'b1;
               wcnt_ff[cur_ff]  <= wcnt_ff[cur_ff] - 1'b1;
               entered_ff       <= entered_ff + 1'b1;
            end
            edc_pkg::S_PP_CHK: begin
               if (!(k_ff == edc_pkg::PPCNT_W'(edc_pkg::POSTPONE_REACH)
                     || (QW'(k_ff) + QW'(1)) >= q_fill_ff))
                  k_ff <= k_ff + 1'b1;
            end
            edc_pkg::S_PP_SWAP: begin
               tmp_ff      <= q_k;
               q_ff[k_idx] <= q_head;
            end
            edc_pkg::S_PP_SWAP2: begin
               q_ff[0] <= tmp_ff;
            end
            edc_pkg::S_DIR_SCAN: begin
               if (q_fill_ff != '0) begin
                  if (idx_ff < cab_fill_ff) begin
                     if (cab_rd == q_head) found_ff <= 1'b1;
                     idx_ff <= idx_ff + 1'b1;
                  end else if (target > cur_ff) begin
                     dir_ff <= 2'b01;
                  end else if (target < cur_ff) begin
                     dir_ff <= 2'b10;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == edc_pkg::S_FINISH && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == edc_pkg::S_FINISH && out_free) begin
         rsp_stopped_ff  <= stopped_ff;
         rsp_up_ff       <= dir_ff[0];
         rsp_down_ff     <= dir_ff[1];
         rsp_move_ff     <= q_fill_ff != '0;
         rsp_cabin_ff    <= cab_fill_ff;
         rsp_exited_ff   <= exited_ff;
         rsp_entered_ff  <= entered_ff;
         rsp_rejected_ff <= rejected_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_stopped       = rsp_stopped_ff;
   assign rsp_going_up      = rsp_up_ff;
   assign rsp_going_down    = rsp_down_ff;
   assign rsp_move_enable   = rsp_move_ff;
   assign rsp_cabin_count   = rsp_cabin_ff;
   assign rsp_exited_count  = rsp_exited_ff;
   assign rsp_entered_count = rsp_entered_ff;
   assign rsp_rejected      = rsp_rejected_ff;

endmodule

// File: design/edc_checker.sv
// edc_checker: port-level checks of the elevator dispatch controller,
// bound to the top level; depends only on the top level's ports
module edc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_stopped,
   input logic       rsp_going_up,
   input logic       rsp_going_down,
   input logic [3:0] rsp_cabin_count,
   input logic [3:0] rsp_exited_count,
   input logic [3:0] rsp_entered_count,
   input logic       rsp_rejected
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cabin_count)
                                  && $stable(rsp_stopped))
      else $error("result changed while stalled");

   a_dir_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_going_up && rsp_going_down))
      else $error("both directions set");

   a_no_stop_no_move: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stopped |-> rsp_exited_count == 4'd0 && rsp_entered_count == 4'd0)
      else $error("riders moved without a stop");

   a_reject_only_call: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> !rsp_stopped && rsp_cabin_count <= 4'd8)
      else $error("rejected with a stop");

endmodule

bind elevator_dispatch_controller_unit edc_checker u_edc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_stopped       (rsp_stopped),
   .rsp_going_up      (rsp_going_up),
   .rsp_going_down    (rsp_going_down),
   .rsp_cabin_count   (rsp_cabin_count),
   .rsp_exited_count  (rsp_exited_count),
   .rsp_entered_count (rsp_entered_count),
   .rsp_rejected      (rsp_rejected)
);

// File: verif/elevator_dispatch_controller_unit_test.sv
// testbench for elevator_dispatch_controller_unit: random and directed calls,
// zone and stop reports checked against a behavioral dispatcher model
// depends on edc_pkg and the design sources
`timescale 1ns / 100ps

module elevator_dispatch_controller_unit_test;

   typedef struct packed {
      logic       stopped;
      logic       going_up;
      logic       going_down;
      logic       move_enable;
      logic [3:0] cabin_count;
      logic [3:0] exited_count;
      logic [3:0] entered_count;
      logic       rejected;
   } status_type;

   class dispatch_scoreboard;
      logic [edc_pkg::FLOOR_W-1:0] wait_dest [edc_pkg::FLOORS][edc_pkg::WAIT_DEPTH];
      int                          wait_cnt  [edc_pkg::FLOORS];
      logic [edc_pkg::PAIR_W-1:0]  riders    [edc_pkg::CABIN_SLOTS];
      int                          rider_cnt;
      logic [edc_pkg::PAIR_W-1:0]  calls     [edc_pkg::QUEUE_DEPTH];
      int                          call_cnt;
      int                          floor_now;
      logic [1:0]                  heading;
      int                          capacity;
      status_type                  pending [$];
      int                          errors;

      function void clear();
         for (int f = 0; f < edc_pkg::FLOORS; f++) wait_cnt[f] = 0;
         rider_cnt = 0;
         call_cnt  = 0;
         floor_now = 0;
         heading   = 2'b00;
         capacity  = 8;
         errors    = 0;
      endfunction

      function int cap_limit();
         return (capacity > edc_pkg::CABIN_SLOTS) ? edc_pkg::CABIN_SLOTS : capacity;
      endfunction

      function void steer();
         int  goal;
         bit  aboard;
         if (call_cnt == 0) return;
         aboard = 0;
         for (int i = 0; i < rider_cnt; i++)
            if (riders[i] == calls[0]) aboard = 1;
         goal = aboard ? calls[0][2:0] : calls[0][5:3];
         if (goal > floor_now) heading = 2'b01;
         else if (goal < floor_now) heading = 2'b10;
      endfunction

      function void drop_call(logic [edc_pkg::PAIR_W-1:0] pair);
         for (int j = 0; j < call_cnt; j++)
            if (calls[j] == pair) begin
               for (int m = j; m < call_cnt - 1; m++) calls[m] = calls[m+1];
               call_cnt--;
               return;
            end
      endfunction

      function void postpone();
         int                         k;
         logic [edc_pkg::PAIR_W-1:0] t;
         if (rider_cnt != cap_limit() || call_cnt == 0) return;
         if (calls[0][5:3] != floor_now) return;
         k = 0;
         while (k < edc_pkg::POSTPONE_REACH && k + 1 < call_cnt) begin
            k++;
            t = calls[0];
            calls[0] = calls[k];
            calls[k] = t;
            if (calls[0] != calls[k]) break;
         end
      endfunction

      function void note_request(logic [1:0] cmd, int fl, int ds);
         status_type r;
         bit         want;
         int         i;
         r = '0;
         if (cmd == edc_pkg::CMD_CALL) begin
            if (fl < edc_pkg::FLOORS && ds < edc_pkg::FLOORS
                && wait_cnt[fl] < edc_pkg::WAIT_DEPTH
                && call_cnt < edc_pkg::QUEUE_DEPTH) begin
               wait_dest[fl][wait_cnt[fl]] = edc_pkg::FLOOR_W'(ds);
               wait_cnt[fl]++;
               calls[call_cnt] = {fl[2:0], ds[2:0]};
               call_cnt++;
            end else
               r.rejected = 1;
         end else if ((cmd == edc_pkg::CMD_ZONE || cmd == edc_pkg::CMD_STOP)
                      && fl < edc_pkg::FLOORS) begin
            floor_now = fl;
            want = 0;
            for (i = 0; i < rider_cnt; i++)
               if (riders[i][2:0] == floor_now) want = 1;
            if (wait_cnt[floor_now] != 0 && rider_cnt < cap_limit()) want = 1;
            if (cmd == edc_pkg::CMD_STOP && want) begin
               r.stopped = 1;
               i = 0;
               while (i < rider_cnt) begin
                  if (riders[i][2:0] == floor_now) begin
                     drop_call(riders[i]);
                     for (int m = i; m < rider_cnt - 1; m++) riders[m] = riders[m+1];
                     rider_cnt--;
                     r.exited_count++;
                  end else
                     i++;
               end
               while (wait_cnt[floor_now] > 0 && rider_cnt < cap_limit()) begin
                  riders[rider_cnt] = {floor_now[2:0], wait_dest[floor_now][0]};
                  rider_cnt++;
                  for (int m = 0; m < wait_cnt[floor_now] - 1; m++)
                     wait_dest[floor_now][m] = wait_dest[floor_now][m+1];
                  wait_cnt[floor_now]--;
                  r.entered_count++;
               end
               postpone();
            end
            steer();
         end
         r.going_up    = heading[0];
         r.going_down  = heading[1];
         r.move_enable = (call_cnt != 0);
         r.cabin_count = 4'(rider_cnt);
         pending.insert(pending.size(), r);
      endfunction

      function void check_status(status_type got);
         status_type e;
         if (pending.size() == 0) begin
            $error("unexpected response transaction");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.stopped !== e.stopped) begin
            $error("stopped: expected %0d actual %0d", e.stopped, got.stopped); errors++; end
         if (got.going_up !== e.going_up) begin
            $error("going_up: expected %0d actual %0d", e.going_up, got.going_up); errors++; end
         if (got.going_down !== e.going_down) begin
            $error("going_down: expected %0d actual %0d", e.going_down, got.going_down);
            errors++; end
         if (got.move_enable !== e.move_enable) begin
            $error("move_enable: expected %0d actual %0d", e.move_enable, got.move_enable);
            errors++; end
         if (got.cabin_count !== e.cabin_count) begin
            $error("cabin_count: expected %0d actual %0d", e.cabin_count, got.cabin_count);
            errors++; end
         if (got.exited_count !== e.exited_count) begin
            $error("exited_count: expected %0d actual %0d", e.exited_count, got.exited_count);
            errors++; end
         if (got.entered_count !== e.entered_count) begin
            $error("entered_count: expected %0d actual %0d", e.entered_count,
                   got.entered_count); errors++; end
         if (got.rejected !== e.rejected) begin
            $error("rejected: expected %0d actual %0d", e.rejected, got.rejected); errors++; end
      endfunction
   endclass

   logic       clock = 0;
   logic       reset = 1;
   logic       csr_write_enable = 0;
   logic [3:0] csr_cabin_capacity = edc_pkg::CAP_RESET;
   logic       req_valid = 0;
   logic       req_ready;
   logic [1:0] req_command = edc_pkg::CMD_CALL;
   logic [2:0] req_floor = 0;
   logic [2:0] req_dest_floor = 0;
   logic       rsp_valid;
   logic       rsp_ready = 0;
   logic       rsp_stopped, rsp_going_up, rsp_going_down, rsp_move_enable, rsp_rejected;
   logic [3:0] rsp_cabin_count, rsp_exited_count, rsp_entered_count;
   status_type rsp;

   dispatch_scoreboard board;
   bit  hold_rsp = 0;
   bit  stim_done = 0;

   assign rsp = {rsp_stopped, rsp_going_up, rsp_going_down, rsp_move_enable,
                 rsp_cabin_count, rsp_exited_count, rsp_entered_count, rsp_rejected};

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   elevator_dispatch_controller_unit DUT (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_cabin_capacity(csr_cabin_capacity),
      .req_valid(req_valid), .req_ready(req_ready), .req_command(req_command),
      .req_floor(req_floor), .req_dest_floor(req_dest_floor),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_stopped(rsp_stopped), .rsp_going_up(rsp_going_up),
      .rsp_going_down(rsp_going_down), .rsp_move_enable(rsp_move_enable),
      .rsp_cabin_count(rsp_cabin_count), .rsp_exited_count(rsp_exited_count),
      .rsp_entered_count(rsp_entered_count), .rsp_rejected(rsp_rejected));

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 40) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // one request transaction, predicted when accepted
   task automatic send_request(logic [1:0] cmd, logic [2:0] fl, logic [2:0] ds);
      req_valid      <= 1;
      req_command    <= cmd;
      req_floor      <= fl;
      req_dest_floor <= ds;
      do @(posedge clock); while (!req_ready);
      board.note_request(cmd, fl, ds);
   endtask

   task automatic idle_request(int n);
      if (n == 0) return;
      req_valid <= 0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_capacity(int c);
      drain();
      csr_write_enable   <= 1;
      csr_cabin_capacity <= 4'(c);
      @(posedge clock);
      csr_write_enable   <= 0;
      board.capacity = c & 15;
   endtask

   // mostly valid calls and stops at random floors in range
   task automatic random_request();
      int p;
      logic [2:0] f;
      p = $urandom_range(0, 99);
      f = 3'($urandom_range(0, edc_pkg::FLOORS - 1));
      if (p < 45)
         send_request(edc_pkg::CMD_CALL, f, 3'($urandom_range(0, edc_pkg::FLOORS - 1)));
      else if (p < 55)
         send_request(edc_pkg::CMD_ZONE, f, 3'($urandom()));
      else if (p < 93)
         send_request(edc_pkg::CMD_STOP, f, 3'($urandom()));
      else
         send_request(2'($urandom()), 3'($urandom()), 3'($urandom()));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_status(rsp);
      rsp_ready <= hold_rsp ? 0 : ($urandom_range(0, 9) < 7);
   end

   // receiver back-pressure: random stalls and one long hold-off
   initial begin
      int n;
      @(negedge reset);
      repeat (2000) @(posedge clock);
      hold_rsp = 1;
      repeat (400) @(posedge clock);
      hold_rsp = 0;
      while (!stim_done) begin
         n = gap_len();
         hold_rsp = (n != 0);
         repeat (n + 1) @(posedge clock);
      end
      hold_rsp = 0;
   end

   initial begin
      board = new();
      board.clear();
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: rejects, extremes, ignored commands, full cabin postpone
      send_request(edc_pkg::CMD_CALL, 3'd7, 3'd1);
      send_request(edc_pkg::CMD_CALL, 3'd1, 3'd7);
      send_request(edc_pkg::CMD_CALL, 3'd4, 3'd0);
      send_request(edc_pkg::CMD_CALL, 3'd0, 3'd4);
      send_request(edc_pkg::CMD_ZONE, 3'd6, 3'd0);
      send_request(edc_pkg::CMD_STOP, 3'd5, 3'd0);
      send_request(2'd3, 3'd7, 3'd7);
      send_request(edc_pkg::CMD_STOP, 3'd0, 3'd0);
      send_request(edc_pkg::CMD_ZONE, 3'd4, 3'd0);
      send_request(edc_pkg::CMD_STOP, 3'd4, 3'd0);
      send_request(edc_pkg::CMD_STOP, 3'd2, 3'd0);
      write_capacity(1);
      send_request(edc_pkg::CMD_CALL, 3'd2, 3'd3);
      send_request(edc_pkg::CMD_CALL, 3'd2, 3'd3);
      send_request(edc_pkg::CMD_CALL, 3'd2, 3'd1);
      send_request(edc_pkg::CMD_STOP, 3'd2, 3'd0);
      send_request(edc_pkg::CMD_STOP, 3'd2, 3'd0);
      send_request(edc_pkg::CMD_STOP, 3'd3, 3'd0);
      send_request(edc_pkg::CMD_STOP, 3'd2, 3'd0);
      for (int i = 0; i < 17; i++)
         send_request(edc_pkg::CMD_CALL, 3'd3, 3'(i % edc_pkg::FLOORS));
      drain();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: write_capacity(8);
            1: write_capacity(15);
            2: write_capacity($urandom_range(2, 7));
            3: write_capacity(0);
            default: write_capacity(1);
         endcase
         for (int i = 0; i < 220; i++) begin
            random_request();
            idle_request(gap_len());
         end
      end
      stim_done = 1;
      drain();
      if (board.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
